// File: src/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg
// Types and constants shared by the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcd4_pkg;

	// request kinds on the input stream
	localparam logic [1:0] KIND_TICK   = 2'd0;
	localparam logic [1:0] KIND_WRITE  = 2'd1;
	localparam logic [1:0] KIND_INIT   = 2'd2;
	localparam logic [1:0] KIND_CURSOR = 2'd3;

	// configuration register indexes
	localparam logic [7:0] CFG_ENABLE_HIGH = 8'd0;
	localparam logic [7:0] CFG_POST_PULSE  = 8'd1;
	localparam logic [7:0] CFG_CLEAR_HOME  = 8'd2;
	localparam logic [7:0] CFG_POWER_ON    = 8'd3;
	localparam logic [7:0] CFG_INIT_FIRST  = 8'd4;
	localparam logic [7:0] CFG_INIT_STEP   = 8'd5;

	// configuration reset values
	localparam logic [7:0]  RST_ENABLE_HIGH = 8'd1;
	localparam logic [15:0] RST_POST_PULSE  = 16'd50;
	localparam logic [15:0] RST_CLEAR_HOME  = 16'd2000;
	localparam logic [15:0] RST_POWER_ON    = 16'd40000;
	localparam logic [15:0] RST_INIT_FIRST  = 16'd5000;
	localparam logic [15:0] RST_INIT_STEP   = 16'd150;

	// controller command codes
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_HOME      = 8'h02;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] LINE2_BASE    = 8'h40;
	localparam logic [7:0] COL_MAX       = 8'd15;
	localparam logic [3:0] NIB_WAKE      = 4'h3;
	localparam logic [3:0] NIB_4BIT      = 4'h2;

	localparam logic [7:0] INIT_CMDS [4] = '{8'h28, 8'h0C, 8'h06, 8'h01};

	// init step numbering: 1..3 wake nibbles, 4 the 4-bit nibble, 5..8 init commands
	localparam logic [3:0] STEP_NONE       = 4'd0;
	localparam logic [3:0] STEP_FIRST_NIB  = 4'd1;
	localparam logic [3:0] STEP_LAST_NIB   = 4'd4;
	localparam logic [3:0] STEP_FIRST_CMD  = 4'd5;
	localparam logic [3:0] STEP_LAST_CHAIN = 4'd7;
	localparam logic [3:0] STEP_MAX        = 4'd8;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_BYTE,
		OP_INIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       rs;
	} item_t;

	typedef struct packed {
		logic [7:0]  enable_high;
		logic [15:0] post_pulse;
		logic [15:0] clear_home;
		logic [15:0] power_on;
		logic [15:0] init_first;
		logic [15:0] init_step;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_POWER,
		PH_EN_HIGH,
		PH_POST,
		PH_LONG,
		PH_INIT_WAIT
	} phase_t;

	// result word, reg_select in bit 0
	typedef struct packed {
		logic       accepted;
		logic       busy;
		logic [3:0] bus_nibble;
		logic       enable;
		logic       reg_select;
	} res_t;

endpackage

`default_nettype wire

// File: src/lcd4_front.sv
// ----------------------------------------------------------------------------
// lcd4_front
// Input stage: takes stream words, decodes the kind and builds the byte to send.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [31:0]     s_tdata,  // byte_value[7:0], is_data[8], column[16:9], row[24:17]
	input  logic [1:0]      s_tuser,  // kind[1:0]
	output logic            item_valid,
	input  logic            item_ready,
	output lcd4_pkg::item_t item
);
	import lcd4_pkg::*;

	logic       v_s1;
	item_t      item_s1;
	item_t      cls;
	logic [7:0] col;
	logic [7:0] base;

	always_comb begin
		col  = (s_tdata[16:9] > COL_MAX) ? COL_MAX : s_tdata[16:9];
		base = (s_tdata[24:17] == 8'd0) ? 8'd0 : LINE2_BASE;
		cls  = '{op: OP_TICK, data_byte: s_tdata[7:0], rs: s_tdata[8]};
		case (s_tuser)
			KIND_TICK: begin
				cls.op = OP_TICK;
			end
			KIND_WRITE: begin
				cls.op = OP_BYTE;
			end
			KIND_INIT: begin
				cls.op = OP_INIT;
			end
			KIND_CURSOR: begin
				cls.op        = OP_BYTE;
				cls.data_byte = CMD_SET_DDRAM | (base + col);
				cls.rs        = 1'b0;
			end
			default: begin
				cls.op = OP_TICK;
			end
		endcase
	end

	assign s_tready   = !v_s1 || item_ready;
	assign item_valid = v_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= cls;
		end
	end

endmodule

`default_nettype wire

// File: src/lcd4_queue.sv
// ----------------------------------------------------------------------------
// lcd4_queue
// Two-entry queue between the decode stage and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lcd4_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output lcd4_pkg::item_t out_item
);
	import lcd4_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t         mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q < CW'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count past depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(QUEUE_DEPTH)) && !pop |=> (count_q == CW'(QUEUE_DEPTH)))
		else $error("full queue changed level without a pop");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// File: src/lcd4_back.sv
// ----------------------------------------------------------------------------
// lcd4_back
// Pin sequencer: applies one item a cycle, unless the output stream stalls, to the pin
// and counter state and registers the resulting pin levels on the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd4_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  lcd4_pkg::item_t item,
	input  lcd4_pkg::cfg_t  cfg,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata
);
	import lcd4_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] cnt_q, cnt_d;
	logic [3:0]  step_q, step_d;
	logic [7:0]  pend_q, pend_d;
	logic        lnn_q, lnn_d;
	logic        rs_q, rs_d;
	logic        en_q, en_d;
	logic [3:0]  bus_q, bus_d;
	logic        acc;

	logic        m_tvalid_q;
	res_t        res_q, res;
	logic        fire;

	logic        start_b;
	logic [7:0]  sb_val;
	logic        sb_rs;
	logic        start_n;
	logic [3:0]  sn_val;
	logic        chain;

	assign fire       = item_valid && (!m_tvalid_q || m_tready);
	assign item_ready = !m_tvalid_q || m_tready;
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = res_q;

	// next state of the sequencer
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		step_d  = step_q;
		pend_d  = pend_q;
		lnn_d   = lnn_q;
		rs_d    = rs_q;
		en_d    = en_q;
		bus_d   = bus_q;
		acc     = 1'b0;
		start_b = 1'b0;
		sb_val  = pend_q;
		sb_rs   = 1'b0;
		start_n = 1'b0;
		sn_val  = bus_q;
		chain   = (step_q >= STEP_FIRST_CMD) && (step_q <= STEP_LAST_CHAIN);

		case (item.op)
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (cnt_q <= 16'd1) begin
						cnt_d = '0;
						case (phase_q)
							PH_POWER: begin
								step_d  = STEP_FIRST_NIB;
								rs_d    = 1'b0;
								lnn_d   = 1'b0;
								start_n = 1'b1;
								sn_val  = NIB_WAKE;
							end
							PH_EN_HIGH: begin
								en_d    = 1'b0;
								cnt_d   = cfg.post_pulse;
								phase_d = PH_POST;
							end
							PH_POST: begin
								if (lnn_q) begin
									lnn_d   = 1'b0;
									start_n = 1'b1;
									sn_val  = pend_q[3:0];
								end else if (step_q >= STEP_FIRST_NIB && step_q <= STEP_LAST_NIB) begin
									cnt_d   = (step_q == STEP_FIRST_NIB) ? cfg.init_first
									                                     : cfg.init_step;
									phase_d = PH_INIT_WAIT;
								end else if (!rs_q && (pend_q == CMD_CLEAR || pend_q == CMD_HOME)) begin
									cnt_d   = cfg.clear_home;
									phase_d = PH_LONG;
								end else if (chain) begin
									step_d  = step_q + 4'd1;
									start_b = 1'b1;
									sb_val  = INIT_CMDS[2'(step_q - STEP_LAST_NIB)];
								end else begin
									step_d  = STEP_NONE;
									phase_d = PH_IDLE;
								end
							end
							PH_LONG: begin
								if (chain) begin
									step_d  = step_q + 4'd1;
									start_b = 1'b1;
									sb_val  = INIT_CMDS[2'(step_q - STEP_LAST_NIB)];
								end else begin
									step_d  = STEP_NONE;
									phase_d = PH_IDLE;
								end
							end
							PH_INIT_WAIT: begin
								if (step_q < STEP_LAST_NIB) begin
									step_d  = step_q + 4'd1;
									lnn_d   = 1'b0;
									start_n = 1'b1;
									sn_val  = (step_q + 4'd1 == STEP_LAST_NIB) ? NIB_4BIT : NIB_WAKE;
								end else begin
									step_d  = STEP_FIRST_CMD;
									start_b = 1'b1;
									sb_val  = INIT_CMDS[0];
								end
							end
							default: begin
								phase_d = PH_IDLE;
							end
						endcase
					end else begin
						cnt_d = cnt_q - 16'd1;
					end
				end
			end
			OP_BYTE: begin
				if (phase_q == PH_IDLE) begin
					acc     = 1'b1;
					step_d  = STEP_NONE;
					start_b = 1'b1;
					sb_val  = item.data_byte;
					sb_rs   = item.rs;
				end
			end
			OP_INIT: begin
				if (phase_q == PH_IDLE) begin
					acc     = 1'b1;
					rs_d    = 1'b0;
					en_d    = 1'b0;
					lnn_d   = 1'b0;
					step_d  = STEP_NONE;
					cnt_d   = cfg.power_on;
					phase_d = PH_POWER;
				end
			end
			default: begin
				acc = 1'b0;
			end
		endcase

		// byte start: latch it, then high nibble goes out first
		if (start_b) begin
			pend_d  = sb_val;
			rs_d    = sb_rs;
			lnn_d   = 1'b1;
			start_n = 1'b1;
			sn_val  = sb_val[7:4];
		end
		if (start_n) begin
			bus_d   = sn_val;
			en_d    = 1'b1;
			cnt_d   = {8'd0, cfg.enable_high};
			phase_d = PH_EN_HIGH;
		end
	end

	// result word from the updated pin state
	always_comb begin
		res.reg_select = rs_d;
		res.enable     = en_d;
		res.bus_nibble = bus_d;
		res.busy       = (phase_d != PH_IDLE);
		res.accepted   = acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			cnt_q      <= '0;
			step_q     <= STEP_NONE;
			pend_q     <= '0;
			lnn_q      <= 1'b0;
			rs_q       <= 1'b0;
			en_q       <= 1'b0;
			bus_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
				step_q  <= step_d;
				pend_q  <= pend_d;
				lnn_q   <= lnn_d;
				rs_q    <= rs_d;
				en_q    <= en_d;
				bus_q   <= bus_d;
			end
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	a_en_phase: assert property (@(posedge clk) disable iff (!arst_n)
		en_q |-> (phase_q == PH_EN_HIGH))
		else $error("enable high outside the pulse phase");

	a_low_pending: assert property (@(posedge clk) disable iff (!arst_n)
		lnn_q |-> (phase_q == PH_EN_HIGH || phase_q == PH_POST))
		else $error("low nibble pending outside a byte transfer");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q <= STEP_MAX) && ((phase_q == PH_IDLE) -> (step_q == STEP_NONE)))
		else $error("init step out of range");

	a_busy_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q != PH_IDLE) |=> !res_q.accepted)
		else $error("request taken while busy");

endmodule

`default_nettype wire

// File: src/char_lcd_4bit_interface_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_4bit_interface_sequencer
// 4-bit character LCD sequencer: ticks, byte writes, init and cursor set.
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  tdata: byte_value, is_data, column, row; tuser: kind
// m        out  m_tvalid/m_tready  tdata: reg_select, enable, bus_nibble, busy_res, accepted
// cfg      in   cfg_we             cfg_index, cfg_data
//
// one word in, one word out; a new word is taken every cycle when m is not stalled
// each word passes the decode register, the queue and the sequencer output register
// the sequencer updates all pin and counter state once for each word it takes
// reset clears the pins, the sequence state and the queue; config goes to defaults
// a stall on m backs up through the two-entry queue to s_tready
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_interface_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // byte_value[7:0], is_data[8], column[16:9], row[24:17]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // reg_select[0], enable[1], bus_nibble[5:2], busy_res[6], accepted[7]
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lcd4_pkg::*;

	cfg_t  cfg_q;
	item_t f_item;
	logic  f_valid;
	logic  f_ready;
	item_t q_item;
	logic  q_valid;
	logic  q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_high <= RST_ENABLE_HIGH;
			cfg_q.post_pulse  <= RST_POST_PULSE;
			cfg_q.clear_home  <= RST_CLEAR_HOME;
			cfg_q.power_on    <= RST_POWER_ON;
			cfg_q.init_first  <= RST_INIT_FIRST;
			cfg_q.init_step   <= RST_INIT_STEP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLE_HIGH: cfg_q.enable_high <= cfg_data[7:0];
				CFG_POST_PULSE:  cfg_q.post_pulse  <= cfg_data;
				CFG_CLEAR_HOME:  cfg_q.clear_home  <= cfg_data;
				CFG_POWER_ON:    cfg_q.power_on    <= cfg_data;
				CFG_INIT_FIRST:  cfg_q.init_first  <= cfg_data;
				CFG_INIT_STEP:   cfg_q.init_step   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lcd4_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	lcd4_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_item  (q_item)
	);

	lcd4_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (q_item),
		.cfg        (cfg_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

`default_nettype wire

// File: test/lcd4_seq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd4_seq_checker
// Watches the request, result and register-write ports of the LCD sequencer,
// keeps its own model of the pin, counter and init-step state, and compares
// every result word field by field with the word predicted for its request.
// ----------------------------------------------------------------------------

module lcd4_seq_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // byte_value[7:0], is_data[8], column[16:9], row[24:17]
	input  logic [1:0]  s_tuser,   // kind[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // reg_select[0], enable[1], bus_nibble[5:2], busy_res[6], accepted[7]
	input  logic        cfg_we,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          words_in_flight,
	output logic        seq_busy
);
	import lcd4_pkg::*;

	localparam int MAX_PRINTED = 20;

	// controller commands and bus nibbles
	localparam logic [7:0] DISP_CLEAR     = 8'h01;
	localparam logic [7:0] CURSOR_HOME    = 8'h02;
	localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
	localparam logic [7:0] LCD_DISPLAY_ON = 8'h0C;
	localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
	localparam logic [7:0] LCD_SET_ADDR   = 8'h80;
	localparam logic [7:0] LCD_LINE1      = 8'h00;
	localparam logic [7:0] LCD_LINE2      = 8'h40;
	localparam logic [7:0] LCD_LAST_COL   = 8'd15;
	localparam logic [3:0] LCD_WAKE_NIB   = 4'h3;
	localparam logic [3:0] LCD_4BIT_NIB   = 4'h2;

	// init progress: wake nibbles, then the command chain
	localparam logic [3:0] SEQ_IDLE     = 4'd0;
	localparam logic [3:0] SEQ_WAKE1    = 4'd1;
	localparam logic [3:0] SEQ_MODE_NIB = 4'd4;
	localparam logic [3:0] SEQ_CMD1     = 4'd5;
	localparam logic [3:0] SEQ_CMD3     = 4'd7;
	localparam logic [3:0] SEQ_LAST     = 4'd8;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] count;
		logic [3:0]  step;
		logic [7:0]  pend;
		logic        low_next;
		logic        rs;
		logic        en;
		logic [3:0]  bus;
	} lcd_state_t;

	lcd_state_t lcd;
	lcd_state_t nx;
	cfg_t       regs;
	res_t       expected_words[$];
	int         words_checked;

	assign seq_busy = (lcd.phase != PH_IDLE);

	task automatic flag(input string msg);
		if (fail_count < MAX_PRINTED) begin
			$display("[%0t] mismatch: %s", $time, msg);
		end
		fail_count++;
	endtask

	function automatic void put_nibble(input logic [3:0] nib);
		nx.bus = nib;
		nx.en = 1'b1;
		nx.count = {8'd0, regs.enable_high};
		nx.phase = PH_EN_HIGH;
	endfunction

	function automatic void put_byte(input logic [7:0] b, input logic rs);
		nx.pend = b;
		nx.rs = rs;
		nx.low_next = 1'b1;
		put_nibble(b[7:4]);
	endfunction

	// end of a byte: either the next init command or back to idle
	function automatic void close_byte();
		if (nx.step >= SEQ_CMD1 && nx.step <= SEQ_CMD3) begin
			nx.step = nx.step + 4'd1;
			if (nx.step == SEQ_LAST) begin
				put_byte(DISP_CLEAR, 1'b0);
			end else if (nx.step == SEQ_CMD3) begin
				put_byte(LCD_ENTRY_MODE, 1'b0);
			end else begin
				put_byte(LCD_DISPLAY_ON, 1'b0);
			end
		end else begin
			nx.step = SEQ_IDLE;
			nx.phase = PH_IDLE;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict_and_check
		res_t        got;
		res_t        want;
		logic [1:0]  kind;
		logic [7:0]  byte_in;
		logic        data_flag;
		logic [7:0]  col;
		logic [7:0]  row_in;
		logic        taken;
		if (!arst_n) begin
			lcd <= '0;
			regs <= {8'd1, 16'd50, 16'd2000, 16'd40000, 16'd5000, 16'd150};
			words_in_flight <= 0;
			fail_count = 0;
			words_checked = 0;
			expected_words.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata);
				if (expected_words.size() == 0) begin
					flag($sformatf("result word %h with no expected word waiting", m_tdata));
				end else begin
					want = expected_words.pop_front();
					if (got.reg_select !== want.reg_select)
						flag($sformatf("word %0d: reg_select %b, expected %b",
							words_checked, got.reg_select, want.reg_select));
					if (got.enable !== want.enable)
						flag($sformatf("word %0d: enable %b, expected %b",
							words_checked, got.enable, want.enable));
					if (got.bus_nibble !== want.bus_nibble)
						flag($sformatf("word %0d: bus_nibble %h, expected %h",
							words_checked, got.bus_nibble, want.bus_nibble));
					if (got.busy !== want.busy)
						flag($sformatf("word %0d: busy_res %b, expected %b",
							words_checked, got.busy, want.busy));
					if (got.accepted !== want.accepted)
						flag($sformatf("word %0d: accepted %b, expected %b",
							words_checked, got.accepted, want.accepted));
				end
				words_checked++;
			end

			if (cfg_we) begin
				case (cfg_index)
					CFG_ENABLE_HIGH: regs.enable_high <= cfg_data[7:0];
					CFG_POST_PULSE:  regs.post_pulse <= cfg_data;
					CFG_CLEAR_HOME:  regs.clear_home <= cfg_data;
					CFG_POWER_ON:    regs.power_on <= cfg_data;
					CFG_INIT_FIRST:  regs.init_first <= cfg_data;
					CFG_INIT_STEP:   regs.init_step <= cfg_data;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				kind = s_tuser;
				byte_in = s_tdata[7:0];
				data_flag = s_tdata[8];
				col = (s_tdata[16:9] > LCD_LAST_COL) ? LCD_LAST_COL : s_tdata[16:9];
				row_in = s_tdata[24:17];
				nx = lcd;
				taken = 1'b0;
				if (kind == KIND_TICK) begin
					if (nx.phase != PH_IDLE) begin
						if (nx.count > 16'd1) begin
							nx.count = nx.count - 16'd1;
						end else begin
							nx.count = '0;
							case (nx.phase)
								PH_POWER: begin
									nx.step = SEQ_WAKE1;
									nx.rs = 1'b0;
									nx.low_next = 1'b0;
									put_nibble(LCD_WAKE_NIB);
								end
								PH_EN_HIGH: begin
									nx.en = 1'b0;
									nx.count = regs.post_pulse;
									nx.phase = PH_POST;
								end
								PH_POST: begin
									if (nx.low_next) begin
										nx.low_next = 1'b0;
										put_nibble(nx.pend[3:0]);
									end else if (nx.step >= SEQ_WAKE1 && nx.step <= SEQ_MODE_NIB) begin
										nx.count = (nx.step == SEQ_WAKE1) ? regs.init_first
											: regs.init_step;
										nx.phase = PH_INIT_WAIT;
									end else if (!nx.rs && (nx.pend == DISP_CLEAR ||
										nx.pend == CURSOR_HOME)) begin
										nx.count = regs.clear_home;
										nx.phase = PH_LONG;
									end else begin
										close_byte();
									end
								end
								PH_LONG: close_byte();
								PH_INIT_WAIT: begin
									nx.step = nx.step + 4'd1;
									if (nx.step <= SEQ_MODE_NIB) begin
										nx.low_next = 1'b0;
										put_nibble((nx.step == SEQ_MODE_NIB) ? LCD_4BIT_NIB : LCD_WAKE_NIB);
									end else begin
										nx.step = SEQ_CMD1;
										put_byte(LCD_FUNC_SET, 1'b0);
									end
								end
								default: nx.phase = PH_IDLE;
							endcase
						end
					end
				end else if (nx.phase == PH_IDLE) begin
					// requests are refused unless the sequencer is idle
					taken = 1'b1;
					nx.step = SEQ_IDLE;
					case (kind)
						KIND_WRITE: put_byte(byte_in, data_flag);
						KIND_INIT: begin
							nx.rs = 1'b0;
							nx.en = 1'b0;
							nx.low_next = 1'b0;
							nx.count = regs.power_on;
							nx.phase = PH_POWER;
						end
						default: put_byte(LCD_SET_ADDR |
							(((row_in == 8'd0) ? LCD_LINE1 : LCD_LINE2) + col), 1'b0);
					endcase
				end
				want.reg_select = nx.rs;
				want.enable = nx.en;
				want.bus_nibble = nx.bus;
				want.busy = (nx.phase != PH_IDLE);
				want.accepted = taken;
				expected_words.push_back(want);
				lcd <= nx;
			end

			words_in_flight <= words_in_flight + int'(s_tvalid && s_tready)
				- int'(m_tvalid && m_tready);
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the 4-bit character LCD sequencer: directed writes, clear and
// home commands, init and cursor sets, then random request and tick traffic
// over several register settings with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb;
	import lcd4_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 4;
	localparam int TAIL_CYCLES    = 8;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int HEAVY_PCT      = 48;
	localparam int LIGHT_PCT      = 10;
	localparam int MODE_SPAN      = 64;

	localparam logic [7:0] CFG_UNUSED_LO = 8'd6;
	localparam logic [7:0] CFG_UNUSED_HI = 8'hFF;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} gap_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // byte_value[7:0], is_data[8], column[16:9], row[24:17]
	logic [1:0]  s_tuser = '0;  // kind[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // reg_select[0], enable[1], bus_nibble[5:2], busy_res[6], accepted[7]
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	gap_mode_t gap_mode = IDLE_NONE;
	int        fail_count;
	int        words_in_flight;
	logic      seq_busy;
	int        quiet_cycles = 0;
	int        n_words = 0;
	int        n_requests = 0;
	int        n_settings = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	char_lcd_4bit_interface_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lcd4_seq_checker lcd_watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.words_in_flight (words_in_flight),
		.seq_busy        (seq_busy)
	);

	always @(posedge clk) begin
		if (gap_mode == IDLE_RECV) begin
			m_tready <= ($urandom_range(99) >= HEAVY_PCT);
		end else if (gap_mode == IDLE_BOTH) begin
			m_tready <= ($urandom_range(99) >= LIGHT_PCT);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// no word moving on either side for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("char_lcd_4bit_interface_sequencer regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_word(input logic [1:0] kind, input logic [7:0] b, input logic rs,
		input logic [7:0] col, input logic [7:0] row);
		int gap_pct;
		gap_pct = (gap_mode == IDLE_SEND) ? HEAVY_PCT : (gap_mode == IDLE_BOTH) ? LIGHT_PCT : 0;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {7'd0, row, col, rs, b};
		do @(posedge clk); while (!s_tready);
		n_words++;
		if (kind != KIND_TICK) n_requests++;
	endtask

	task automatic send_tick();
		send_word(KIND_TICK, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// seq_busy lags one word, so the first tick always goes out
	task automatic run_to_idle();
		do send_tick(); while (seq_busy);
	endtask

	task automatic request_and_finish(input logic [1:0] kind, input logic [7:0] b,
		input logic rs, input logic [7:0] col, input logic [7:0] row);
		send_word(kind, b, rs, col, row);
		run_to_idle();
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] eh, input logic [15:0] pp,
		input logic [15:0] ch, input logic [15:0] po, input logic [15:0] fi,
		input logic [15:0] st, input bit stray);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(CFG_ENABLE_HIGH, {8'd0, eh});
		write_reg(CFG_POST_PULSE, pp);
		write_reg(CFG_CLEAR_HOME, ch);
		write_reg(CFG_POWER_ON, po);
		write_reg(CFG_INIT_FIRST, fi);
		write_reg(CFG_INIT_STEP, st);
		if (stray) begin
			write_reg(CFG_UNUSED_LO, 16'hFFFF);
			write_reg(CFG_UNUSED_HI, 16'hFFFF);
		end
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	// mostly ticks while busy so sequences run to completion; requests favored when idle
	task automatic send_random_word();
		logic [1:0] kind;
		logic [7:0] b;
		logic [7:0] col;
		logic [7:0] row;
		int         r;
		r = $urandom_range(99);
		kind = KIND_TICK;
		if (seq_busy ? (r < 6) : (r < 55)) begin
			r = $urandom_range(99);
			kind = (r < 45) ? KIND_WRITE : (r < 60) ? KIND_INIT : KIND_CURSOR;
		end
		b = ($urandom_range(99) < 20) ? ($urandom_range(1) ? CMD_CLEAR : CMD_HOME)
			: 8'($urandom);
		col = $urandom_range(1) ? 8'($urandom_range(20)) : 8'($urandom);
		row = $urandom_range(1) ? 8'd0 : 8'($urandom);
		send_word(kind, b, 1'($urandom), col, row);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			gap_mode <= gap_mode_t'((i / MODE_SPAN) % 4);
			send_random_word();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: idle tick, a data write, refused requests while busy
		send_tick();
		send_word(KIND_WRITE, 8'hA5, 1'b1, 8'd0, 8'd0);
		send_word(KIND_WRITE, CMD_CLEAR, 1'b0, 8'd0, 8'd0);
		send_word(KIND_INIT, 8'h00, 1'b0, 8'd0, 8'd0);
		send_word(KIND_CURSOR, 8'h00, 1'b0, 8'hFF, 8'hFF);
		repeat (12) send_tick();

		// new values while the settle wait is still counting; zero counts; stray indexes
		load_settings(8'd0, 16'd1, 16'd3, 16'd2, 16'd2, 16'd0, 1'b1);
		run_to_idle();
		request_and_finish(KIND_WRITE, CMD_CLEAR, 1'b0, 8'd0, 8'd0);
		request_and_finish(KIND_WRITE, CMD_HOME, 1'b0, 8'd0, 8'd0);
		request_and_finish(KIND_WRITE, CMD_CLEAR, 1'b1, 8'd0, 8'd0);
		request_and_finish(KIND_WRITE, 8'h00, 1'b0, 8'd0, 8'd0);
		request_and_finish(KIND_WRITE, 8'hFF, 1'b1, 8'hFF, 8'hFF);
		request_and_finish(KIND_WRITE, 8'hF0, 1'b0, 8'd0, 8'd0);
		send_word(KIND_INIT, 8'h00, 1'b0, 8'd0, 8'd0);
		send_word(KIND_WRITE, 8'h55, 1'b1, 8'd0, 8'd0);
		run_to_idle();
		request_and_finish(KIND_CURSOR, 8'h00, 1'b0, 8'd0, 8'd0);
		request_and_finish(KIND_CURSOR, 8'h00, 1'b0, 8'd15, 8'd0);
		request_and_finish(KIND_CURSOR, 8'h00, 1'b0, 8'd16, 8'd1);
		request_and_finish(KIND_CURSOR, 8'hFF, 1'b1, 8'hFF, 8'hFF);
		request_and_finish(KIND_CURSOR, 8'h00, 1'b0, 8'd3, 8'h80);

		load_settings(8'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
		run_random(380);
		load_settings(8'($urandom_range(1, 3)), 16'($urandom_range(1, 4)),
			16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
			16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)), 1'b0);
		run_random(380);
		load_settings(8'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
			16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)),
			16'($urandom_range(1, 20)), 16'($urandom_range(1, 10)), 1'b0);
		run_random(380);
		// largest counts last, the sequencer is never brought back to idle
		load_settings(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		run_random(250);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d input words (%0d requests) over %0d register settings",
			n_words, n_requests, n_settings);
		$display("traffic ran with no idling, sender gaps, receiver stalls and both; %0d mismatches",
			fail_count);
		if (fail_count == 0) begin
			$display("char_lcd_4bit_interface_sequencer regression: pass");
		end else begin
			$display("char_lcd_4bit_interface_sequencer regression: fail");
		end
		$finish;
	end

endmodule
